/* hdl/touch_bar_cluster_centroid_defines.svh */
// ----------------------------------------------------------------------------
// Touch-bar cluster centroid: assertion macros
// Shared property forms for the checks at the end of the top level. Both
// forms sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TOUCH_BAR_CLUSTER_CENTROID_DEFINES_SVH
`define TOUCH_BAR_CLUSTER_CENTROID_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TBCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TBCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tbcc_pkg.sv */
// ----------------------------------------------------------------------------
// Touch-bar cluster centroid package
// Widths, electrode position tables and the reciprocal table used by the
// rounding divider.
// ----------------------------------------------------------------------------
package tbcc_pkg;

  // Geometry of the bar.
  localparam int ELECTRODES   = 12;
  localparam int SPAN         = 5;
  localparam int MAX_CLUSTERS = 3;

  // Field and datapath widths.
  localparam int IDX_W   = 4;   // electrode index
  localparam int CNT_W   = 3;   // electrodes in a cluster, 0 to 5
  localparam int CCNT_W  = 2;   // clusters in a mask, 0 to 3
  localparam int LAT_W   = 13;
  localparam int FWD_W   = 12;
  localparam int SUM_W   = 16;  // signed sum of up to five entries
  localparam int MAG_W   = 14;  // magnitude of a sum plus rounding bias
  localparam int RCP_W   = 18;  // reciprocal, scaled by 2**RCP_SHIFT
  localparam int RCP_SHIFT = 17;
  localparam int PROD_W  = MAG_W + RCP_W;

  // One cluster: first electrode and the five-electrode window from there.
  typedef struct packed {
    logic [IDX_W-1:0] start;
    logic [SPAN-1:0]  win;
  } clus_t;

  // State carried along the scan stages.
  typedef struct packed {
    logic [CCNT_W-1:0]               count;
    logic [ELECTRODES-1:0]           rem;
    clus_t [MAX_CLUSTERS-1:0]        clus;
  } scan_t;

  // Result of one scan step.
  typedef struct packed {
    logic                  found;
    clus_t                 clus;
    logic [ELECTRODES-1:0] rem;
  } det_t;

  // Lateral position of each electrode in hundredths of a centimetre.
  function automatic logic signed [LAT_W-1:0] lateral_entry(input logic [IDX_W-1:0] idx);
    logic signed [LAT_W-1:0] v;
    case (idx)
      4'd0:    v = -13'sd2860;
      4'd1:    v = -13'sd2390;
      4'd2:    v = -13'sd2010;
      4'd3:    v = -13'sd1430;
      4'd4:    v = -13'sd950;
      4'd5:    v = -13'sd470;
      4'd6:    v = 13'sd0;
      4'd7:    v = 13'sd480;
      4'd8:    v = 13'sd980;
      4'd9:    v = 13'sd1460;
      4'd10:   v = 13'sd1940;
      4'd11:   v = 13'sd2420;
      default: v = 13'sd0;
    endcase
    return v;
  endfunction

  // Forward distance of each electrode in hundredths of a centimetre.
  function automatic logic [FWD_W-1:0] forward_entry(input logic [IDX_W-1:0] idx);
    logic [FWD_W-1:0] v;
    case (idx)
      4'd0:    v = 12'd589;
      4'd1:    v = 12'd1678;
      4'd2:    v = 12'd2118;
      4'd3:    v = 12'd2546;
      4'd4:    v = 12'd2761;
      4'd5:    v = 12'd2882;
      4'd6:    v = 12'd2920;
      4'd7:    v = 12'd2820;
      4'd8:    v = 12'd2751;
      4'd9:    v = 12'd2529;
      4'd10:   v = 12'd2182;
      4'd11:   v = 12'd1634;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  // Ceiling of 2**17 / n. The product with any magnitude below 2**15 gives
  // the exact floor quotient after the shift. An empty slot divides to 0.
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] v;
    case (n)
      3'd1:    v = 18'd131072;
      3'd2:    v = 18'd65536;
      3'd3:    v = 18'd43691;
      3'd4:    v = 18'd32768;
      3'd5:    v = 18'd26215;
      default: v = 18'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/touch_bar_cluster_centroid.sv */
// ----------------------------------------------------------------------------
// Touch-bar cluster centroid
// Finds up to three electrode clusters in a 12-bit touch mask and reports
// the mean lateral offset and forward distance of each.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (valid_i, stall_o, touch_mask_i) carries one mask per
// transaction; the output channel (valid_o, stall_i and the result fields)
// carries one result transaction per mask, in order.
// A mask passes three scan stages (one cluster found in each), a summing
// stage, the two divider stages and the output register that presents it.
// One mask is accepted every cycle unless the pipeline holds; the rate is
// set by the pipeline, whose stages each hold one mask.
// When the receiver stalls a valid result, the whole pipeline holds and a
// one-entry skid buffer at the input absorbs the transaction in flight;
// stall_o is that buffer's full flag, so it comes straight from a register.
// Reset clears all valid flags and the skid buffer; no result is presented
// until a mask has been accepted.
// ----------------------------------------------------------------------------
`include "touch_bar_cluster_centroid_defines.svh"

module touch_bar_cluster_centroid (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic [tbcc_pkg::ELECTRODES-1:0]     touch_mask_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic [tbcc_pkg::CCNT_W-1:0]         cluster_count_o,
  output logic signed [tbcc_pkg::LAT_W-1:0]   lateral_0_o,
  output logic signed [tbcc_pkg::LAT_W-1:0]   lateral_1_o,
  output logic signed [tbcc_pkg::LAT_W-1:0]   lateral_2_o,
  output logic [tbcc_pkg::FWD_W-1:0]          forward_0_o,
  output logic [tbcc_pkg::FWD_W-1:0]          forward_1_o,
  output logic [tbcc_pkg::FWD_W-1:0]          forward_2_o
);

  localparam int NC = tbcc_pkg::MAX_CLUSTERS;

  // Finds the lowest set electrode, its window and the electrodes left over.
  function automatic tbcc_pkg::det_t detect(input logic [tbcc_pkg::ELECTRODES-1:0] m);
    tbcc_pkg::det_t                    r;
    logic [tbcc_pkg::ELECTRODES-1:0]   shifted;
    logic [tbcc_pkg::ELECTRODES-1:0]   below;
    logic [tbcc_pkg::IDX_W:0]          shamt;
    r = '0;
    for (int i = tbcc_pkg::ELECTRODES - 1; i >= 0; i--) begin
      if (m[i]) begin
        r.found      = 1'b1;
        r.clus.start = tbcc_pkg::IDX_W'(i);
      end
    end
    shifted    = m >> r.clus.start;
    r.clus.win = r.found ? shifted[tbcc_pkg::SPAN-1:0] : '0;
    shamt      = {1'b0, r.clus.start} + (tbcc_pkg::IDX_W + 1)'(tbcc_pkg::SPAN);
    below      = (tbcc_pkg::ELECTRODES'(1) << shamt) - tbcc_pkg::ELECTRODES'(1);
    r.rem      = m & ~below;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input skid buffer and pipeline enable
  // --------------------------------------------------------------------------
  logic                              en;
  logic                              in_take;
  logic                              skid_valid_d, skid_valid_q;
  logic [tbcc_pkg::ELECTRODES-1:0]   skid_mask_q;
  logic                              src_valid;
  logic [tbcc_pkg::ELECTRODES-1:0]   src_mask;
  logic                              out_valid_q;

  assign en        = !(out_valid_q && stall_i);
  assign stall_o   = skid_valid_q;
  assign in_take   = valid_i && !skid_valid_q;
  assign src_valid = skid_valid_q || in_take;
  assign src_mask  = skid_valid_q ? skid_mask_q : touch_mask_i;

  // The buffer fills only when a transaction arrives while the pipeline holds.
  always_comb begin
    skid_valid_d = skid_valid_q;
    if (en) begin
      skid_valid_d = 1'b0;
    end else if (in_take) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_take) begin
      skid_mask_q <= touch_mask_i;
    end
  end

  // --------------------------------------------------------------------------
  // Scan stages: stage k finds cluster k in what the earlier stages left
  // --------------------------------------------------------------------------
  tbcc_pkg::scan_t  scan_in [NC];
  tbcc_pkg::scan_t  scan_d  [NC];
  tbcc_pkg::scan_t  scan_q  [NC];
  logic             scan_vin[NC];
  logic             scan_valid_q [NC];

  always_comb begin
    scan_in[0]       = '0;
    scan_in[0].rem   = src_mask;
    scan_vin[0]      = src_valid;
    for (int k = 1; k < NC; k++) begin
      scan_in[k]  = scan_q[k-1];
      scan_vin[k] = scan_valid_q[k-1];
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_scan
    tbcc_pkg::det_t det;

    // Record the cluster, if any, and drop the electrodes it covers.
    always_comb begin
      det       = detect(scan_in[k].rem);
      scan_d[k] = scan_in[k];
      scan_d[k].rem = det.rem;
      if (det.found) begin
        scan_d[k].clus[k] = det.clus;
        scan_d[k].count   = scan_in[k].count + tbcc_pkg::CCNT_W'(1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        scan_valid_q[k] <= 1'b0;
      end else if (en) begin
        scan_valid_q[k] <= scan_vin[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        scan_q[k] <= scan_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Summing stage: table entries of the set electrodes in each window
  // --------------------------------------------------------------------------
  logic signed [tbcc_pkg::SUM_W-1:0]  lat_sum_d [NC];
  logic signed [tbcc_pkg::SUM_W-1:0]  fwd_sum_d [NC];
  logic        [tbcc_pkg::CNT_W-1:0]  n_d       [NC];
  logic signed [tbcc_pkg::SUM_W-1:0]  lat_sum_q [NC];
  logic signed [tbcc_pkg::SUM_W-1:0]  fwd_sum_q [NC];
  logic        [tbcc_pkg::CNT_W-1:0]  n_q       [NC];
  logic                               sum_valid_q;
  logic        [tbcc_pkg::CCNT_W-1:0] sum_count_q;

  always_comb begin
    logic [tbcc_pkg::IDX_W-1:0] idx;
    for (int c = 0; c < NC; c++) begin
      lat_sum_d[c] = '0;
      fwd_sum_d[c] = '0;
      n_d[c]       = tbcc_pkg::CNT_W'($countones(scan_q[NC-1].clus[c].win));
      for (int j = 0; j < tbcc_pkg::SPAN; j++) begin
        idx = scan_q[NC-1].clus[c].start + tbcc_pkg::IDX_W'(j);
        if (scan_q[NC-1].clus[c].win[j]) begin
          lat_sum_d[c] = lat_sum_d[c] + tbcc_pkg::SUM_W'(tbcc_pkg::lateral_entry(idx));
          fwd_sum_d[c] = fwd_sum_d[c]
                       + $signed({{(tbcc_pkg::SUM_W - tbcc_pkg::FWD_W){1'b0}},
                                  tbcc_pkg::forward_entry(idx)});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (en) begin
      sum_valid_q <= scan_valid_q[NC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_count_q <= scan_q[NC-1].count;
      lat_sum_q   <= lat_sum_d;
      fwd_sum_q   <= fwd_sum_d;
      n_q         <= n_d;
    end
  end

  // --------------------------------------------------------------------------
  // Rounding dividers, two stages, with valid and count carried alongside
  // --------------------------------------------------------------------------
  logic signed [tbcc_pkg::LAT_W-1:0]  lat_quot [NC];
  logic signed [tbcc_pkg::LAT_W-1:0]  fwd_quot [NC];
  logic                               div_valid_q [2];
  logic        [tbcc_pkg::CCNT_W-1:0] div_count_q [2];

  for (genvar c = 0; c < NC; c++) begin : g_div
    tbcc_round_div u_lat_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .sum_i  (lat_sum_q[c]),
      .cnt_i  (n_q[c]),
      .quot_o (lat_quot[c])
    );

    tbcc_round_div u_fwd_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .sum_i  (fwd_sum_q[c]),
      .cnt_i  (n_q[c]),
      .quot_o (fwd_quot[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid_q[0] <= 1'b0;
      div_valid_q[1] <= 1'b0;
    end else if (en) begin
      div_valid_q[0] <= sum_valid_q;
      div_valid_q[1] <= div_valid_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_count_q[0] <= sum_count_q;
      div_count_q[1] <= div_count_q[0];
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [tbcc_pkg::CCNT_W-1:0]        out_count_q;
  logic signed [tbcc_pkg::LAT_W-1:0]  out_lat_q [NC];
  logic [tbcc_pkg::FWD_W-1:0]         out_fwd_q [NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid_q[1];
    end
  end

  // Forward means are never negative, so the low bits carry the whole value.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_count_q <= div_count_q[1];
      for (int c = 0; c < NC; c++) begin
        out_lat_q[c] <= lat_quot[c];
        out_fwd_q[c] <= fwd_quot[c][tbcc_pkg::FWD_W-1:0];
      end
    end
  end

  assign valid_o         = out_valid_q;
  assign cluster_count_o = out_count_q;
  assign lateral_0_o     = out_lat_q[0];
  assign lateral_1_o     = out_lat_q[1];
  assign lateral_2_o     = out_lat_q[2];
  assign forward_0_o     = out_fwd_q[0];
  assign forward_1_o     = out_fwd_q[1];
  assign forward_2_o     = out_fwd_q[2];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TBCC_ASSERT_NEXT(a_skid_drains, skid_valid_q && en, !skid_valid_q, "skid buffer did not drain")
  `TBCC_ASSERT_SAME(a_empty_mask_zero, out_valid_q && (out_count_q == 2'd0),
                    (out_lat_q[0] == 13'sd0) && (out_fwd_q[0] == 12'd0),
                    "empty mask gave a nonzero first slot")
  `TBCC_ASSERT_SAME(a_third_slot_zero, out_valid_q && (out_count_q != 2'd3),
                    (out_lat_q[2] == 13'sd0) && (out_fwd_q[2] == 12'd0),
                    "absent third cluster gave a nonzero slot")

endmodule

/* hdl/tbcc_round_div.sv */
// ----------------------------------------------------------------------------
// Touch-bar cluster centroid: rounding divider
// Divides a signed sum by an electrode count of 1 to 5, rounding to nearest
// with halves away from zero, over two register stages.
// ----------------------------------------------------------------------------
module tbcc_round_div (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [tbcc_pkg::SUM_W-1:0]   sum_i,
  input  logic        [tbcc_pkg::CNT_W-1:0]   cnt_i,
  output logic signed [tbcc_pkg::LAT_W-1:0]   quot_o
);

  logic        [tbcc_pkg::SUM_W-1:0]  abs_sum;
  logic        [tbcc_pkg::MAG_W-1:0]  mag_d, mag_q;
  logic        [tbcc_pkg::RCP_W-1:0]  rcp_d, rcp_q;
  logic                               sign_q, sign_p_q;
  logic        [tbcc_pkg::PROD_W-1:0] prod_d, prod_q;
  logic        [tbcc_pkg::LAT_W-1:0]  quot_mag;

  // Magnitude of the sum plus half the divisor, and the divisor's reciprocal.
  always_comb begin
    abs_sum = sum_i[tbcc_pkg::SUM_W-1] ? (-sum_i) : sum_i;
    mag_d   = abs_sum[tbcc_pkg::MAG_W-1:0] + tbcc_pkg::MAG_W'(cnt_i >> 1);
    rcp_d   = tbcc_pkg::recip(cnt_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      rcp_q  <= rcp_d;
      sign_q <= sum_i[tbcc_pkg::SUM_W-1];
    end
  end

  // Multiply by the reciprocal.
  assign prod_d = tbcc_pkg::PROD_W'(mag_q) * tbcc_pkg::PROD_W'(rcp_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= prod_d;
      sign_p_q <= sign_q;
    end
  end

  // The quotient is a mean of table entries, so it stays below 4096 and
  // fits the low bits above the binary point.
  assign quot_mag = prod_q[tbcc_pkg::RCP_SHIFT + tbcc_pkg::LAT_W - 1:tbcc_pkg::RCP_SHIFT];
  assign quot_o   = sign_p_q ? $signed(-quot_mag) : $signed(quot_mag);

endmodule
